/* sv/lmda_pkg.sv */
// Package for the landmark data association core: sizes, field codes,
// register indexes and the landmark table entry type. No dependencies.
package lmda_pkg;

	localparam int MAX_LANDMARKS = 256;
	localparam int LM_AW         = $clog2(MAX_LANDMARKS);
	localparam int LM_CW         = LM_AW + 1;

	localparam int IN_DATA_W  = 216;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_AW     = 3;
	localparam int CFG_DW     = 32;

	localparam int DIV_W = 99;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;

	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_ASSOC  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_MATCHED = 2'd0,
		ST_NEW     = 2'd1,
		ST_NONE    = 2'd2
	} status_t;

	localparam logic [CFG_AW-1:0] REG_NOISE_XX   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_NOISE_XY   = 3'd1;
	localparam logic [CFG_AW-1:0] REG_NOISE_YX   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_NOISE_YY   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_DIST_GATE  = 3'd4;
	localparam logic [CFG_AW-1:0] REG_CONF_GATE  = 3'd5;

	typedef struct packed {
		logic signed [31:0] cov_d;
		logic signed [31:0] cov_c;
		logic signed [31:0] cov_b;
		logic signed [31:0] cov_a;
		logic signed [31:0] y;
		logic signed [31:0] x;
	} lm_entry_t;

	function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v[32] != v[31]) begin
			r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return r;
	endfunction

endpackage

/* sv/ml_landmark_data_association_core.sv */
// Maximum-likelihood landmark data association core.
// Depends on lmda_pkg for sizes, codes and the landmark entry type.
//
// Usage: input words arrive on s_axis; tuser carries the function code (clear,
// append or associate), tdata the position, covariance and confidence. Clear
// and append words produce no result and are handled in the idle state. An
// associate word produces one result word on m_axis: tuser is the status, tdata
// the slot. Configuration registers are to be written through cfg_we, cfg_addr
// and cfg_wdata only while the core is idle; the core does not enforce this.
// The landmark table is a single 256-entry synchronous memory read one entry
// at a time. Each landmark goes through a shared 34x34 multiplier (eleven
// products for the determinant and the quadratic form), a bit-serial divider
// of 99 steps, a normalisation and sixteen squaring steps for the logarithm;
// singular or gated landmarks skip the later steps. An associate word visits
// every stored landmark in turn.
// The next input word is accepted once the previous one is processed; a result
// waits in the output register while the receiver stalls, and the core holds
// its final step until that register is free. Reset empties the table and sets
// the configuration registers to their defaults; table contents are not cleared.
module ml_landmark_data_association_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pos_x, pos_y, cov_a, cov_b, cov_c, cov_d, confidence, zero pad
	input  logic [lmda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// func
	input  logic [1:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// landmark_slot
	output logic [lmda_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [1:0]                      m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [lmda_pkg::CFG_AW-1:0]     cfg_addr,
	input  logic [lmda_pkg::CFG_DW-1:0]     cfg_wdata
);
	import lmda_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SUM, S_MUL, S_CHK, S_DIV, S_NISC,
		S_NORM, S_LOG, S_LNI, S_LNC, S_NEXT, S_DONE
	} state_t;

	state_t state_q;

	logic [30:0]        noise_xx_q, noise_yy_q, dist_gate_q;
	logic signed [31:0] noise_xy_q, noise_yx_q;
	logic [16:0]        conf_gate_q;

	logic [LM_CW-1:0] cnt_q, j_q;
	lm_entry_t        mem [MAX_LANDMARKS];
	lm_entry_t        rd_q, wr_entry;
	logic             wr_en;

	logic signed [31:0] obs_x_q, obs_y_q;
	logic [16:0]        obs_conf_q;

	logic signed [31:0] a_q, b_q, c_q, d_q;
	logic signed [32:0] x_q, y_q, bc_q;
	logic [3:0]         k_q;
	logic signed [33:0] opa, opb;
	logic signed [67:0] prod_q;
	logic signed [99:0] prod_ext;
	logic signed [64:0] det_q;
	logic signed [65:0] xx_q, xy_q, yy_q;
	logic signed [99:0] num_q, num_abs;

	logic [63:0]       dn_q;
	logic [DIV_W-1:0]  nq_q;
	logic [63:0]       rem_q;
	logic [6:0]        dc_q;
	logic              negq_q;
	logic [64:0]       r2;
	logic              ge;

	logic              sat;
	logic [48:0]       qm;
	logic signed [49:0] nis, nis_q;
	logic [63:0]       detf;

	logic [63:0]  val_q;
	logic [5:0]   e_q;
	logic [2:0]   n_q;
	logic [30:0]  m_q;
	logic [15:0]  frac_q;
	logic [3:0]   it_q;
	logic         ph_q;
	logic [31:0]  sq;

	logic signed [22:0] l2;
	logic [21:0]        l2_mag;
	logic [55:0]        rnd;
	logic signed [49:0] ln_v, cost;
	logic signed [49:0] best_cost_q;
	logic [LM_AW-1:0]   best_slot_q;
	logic               found_q;

	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;
	logic [1:0]            m_user_q;

	logic  acc;
	func_t func;

	assign s_axis_tready = (state_q == S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign func          = func_t'(s_axis_tuser);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	assign wr_en    = acc && (func == FUNC_APPEND) && (cnt_q < LM_CW'(MAX_LANDMARKS));
	assign wr_entry = '{cov_d: s_axis_tdata[191:160], cov_c: s_axis_tdata[159:128],
		cov_b: s_axis_tdata[127:96], cov_a: s_axis_tdata[95:64],
		y: s_axis_tdata[63:32], x: s_axis_tdata[31:0]};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[LM_AW-1:0]] <= wr_entry;
		end
		if (state_q == S_RD) begin
			rd_q <= mem[j_q[LM_AW-1:0]];
		end
	end

	always_comb begin
		opa = '0;
		opb = '0;
		l2     = {7'({1'b0, e_q} - 7'd32), frac_q};
		l2_mag = l2[22] ? 22'(-l2) : 22'(l2);
		if (state_q == S_MUL) begin
			unique case (k_q)
				4'd0:  begin opa = 34'(a_q);  opb = 34'(d_q); end
				4'd1:  begin opa = 34'(b_q);  opb = 34'(c_q); end
				4'd2:  begin opa = 34'(x_q);  opb = 34'(x_q); end
				4'd3:  begin opa = 34'(x_q);  opb = 34'(y_q); end
				4'd4:  begin opa = 34'(y_q);  opb = 34'(y_q); end
				4'd5:  begin opa = 34'(d_q);  opb = {2'b00, xx_q[31:0]}; end
				4'd6:  begin opa = 34'(d_q);  opb = xx_q[65:32]; end
				4'd7:  begin opa = 34'(bc_q); opb = {2'b00, xy_q[31:0]}; end
				4'd8:  begin opa = 34'(bc_q); opb = xy_q[65:32]; end
				4'd9:  begin opa = 34'(a_q);  opb = {2'b00, yy_q[31:0]}; end
				4'd10: begin opa = 34'(a_q);  opb = yy_q[65:32]; end
				default: begin opa = '0; opb = '0; end
			endcase
		end else if (state_q == S_LOG) begin
			opa = {3'b000, m_q};
			opb = {3'b000, m_q};
		end else if (state_q == S_LNI) begin
			opa = {12'd0, l2_mag};
			opb = {2'b00, LN2_Q32};
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	always_comb begin
		prod_ext = 100'(prod_q);
		num_abs  = num_q[99] ? -num_q : num_q;
		r2       = {rem_q, nq_q[DIV_W-1]};
		ge       = (r2 >= {1'b0, dn_q});
		sat      = |nq_q[DIV_W-1:48];
		qm       = sat ? 49'h1_0000_0000_0000
		               : {1'b0, nq_q[47:0]} + 49'(negq_q && (rem_q != '0));
		nis      = negq_q ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		detf     = (det_q < 65'sd4) ? 64'd4 : det_q[63:0];
		sq       = prod_q[61:30];
		rnd      = prod_q[55:0] + 56'h8000_0000;
		ln_v     = l2[22] ? -$signed(50'(rnd[55:32])) : $signed(50'(rnd[55:32]));
		cost     = nis_q + ln_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			found_q     <= 1'b0;
			m_valid_q   <= 1'b0;
			noise_xx_q  <= 31'd655;
			noise_xy_q  <= '0;
			noise_yx_q  <= '0;
			noise_yy_q  <= 31'd655;
			dist_gate_q <= 31'd589824;
			conf_gate_q <= 17'd32768;
		end else begin
			if (m_valid_q && m_axis_tready && (state_q != S_DONE)) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_NOISE_XX:  noise_xx_q  <= cfg_wdata[30:0];
					REG_NOISE_XY:  noise_xy_q  <= cfg_wdata;
					REG_NOISE_YX:  noise_yx_q  <= cfg_wdata;
					REG_NOISE_YY:  noise_yy_q  <= cfg_wdata[30:0];
					REG_DIST_GATE: dist_gate_q <= cfg_wdata[30:0];
					REG_CONF_GATE: conf_gate_q <= cfg_wdata[16:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (func)
							FUNC_CLEAR: cnt_q <= '0;
							FUNC_APPEND: begin
								if (wr_en) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							FUNC_ASSOC: begin
								obs_x_q    <= s_axis_tdata[31:0];
								obs_y_q    <= s_axis_tdata[63:32];
								obs_conf_q <= s_axis_tdata[208:192];
								j_q        <= '0;
								found_q    <= 1'b0;
								state_q    <= S_RD;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					state_q <= (j_q == cnt_q) ? S_DONE : S_SUM;
				end
				S_SUM: begin
					a_q <= sat32(33'(rd_q.cov_a) + $signed({2'b00, noise_xx_q}));
					b_q <= sat32(33'(rd_q.cov_b) + 33'(noise_xy_q));
					c_q <= sat32(33'(rd_q.cov_c) + 33'(noise_yx_q));
					d_q <= sat32(33'(rd_q.cov_d) + $signed({2'b00, noise_yy_q}));
					x_q <= 33'(obs_x_q) - 33'(rd_q.x);
					y_q <= 33'(obs_y_q) - 33'(rd_q.y);
					k_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					k_q <= k_q + 1'b1;
					if (k_q == 4'd0) begin
						bc_q <= 33'(b_q) + 33'(c_q);
					end
					unique case (k_q)
						4'd1:  det_q <= prod_q[64:0];
						4'd2:  det_q <= det_q - prod_q[64:0];
						4'd3:  xx_q  <= prod_q[65:0];
						4'd4:  xy_q  <= prod_q[65:0];
						4'd5:  yy_q  <= prod_q[65:0];
						4'd6:  num_q <= prod_ext;
						4'd7:  num_q <= num_q + (prod_ext <<< 32);
						4'd8:  num_q <= num_q - prod_ext;
						4'd9:  num_q <= num_q - (prod_ext <<< 32);
						4'd10: num_q <= num_q + prod_ext;
						4'd11: begin
							num_q   <= num_q + (prod_ext <<< 32);
							state_q <= S_CHK;
						end
						default: ;
					endcase
				end
				S_CHK: begin
					if (det_q == '0) begin
						state_q <= S_NEXT;
					end else begin
						dn_q    <= det_q[64] ? 64'(-det_q) : det_q[63:0];
						nq_q    <= num_abs[DIV_W-1:0];
						rem_q   <= '0;
						dc_q    <= '0;
						negq_q  <= num_q[99] ^ det_q[64];
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= ge ? 64'(r2 - {1'b0, dn_q}) : r2[63:0];
					nq_q  <= {nq_q[DIV_W-2:0], ge};
					dc_q  <= dc_q + 1'b1;
					if (dc_q == 7'(DIV_W - 1)) begin
						state_q <= S_NISC;
					end
				end
				S_NISC: begin
					if (nis >= $signed({19'd0, dist_gate_q})) begin
						state_q <= S_NEXT;
					end else begin
						nis_q   <= nis;
						val_q   <= detf;
						e_q     <= 6'd63;
						n_q     <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					n_q <= n_q + 1'b1;
					unique case (n_q)
						3'd0: if (val_q[63:32] == '0) begin
							val_q <= val_q << 32; e_q <= e_q - 6'd32;
						end
						3'd1: if (val_q[63:48] == '0) begin
							val_q <= val_q << 16; e_q <= e_q - 6'd16;
						end
						3'd2: if (val_q[63:56] == '0) begin
							val_q <= val_q << 8; e_q <= e_q - 6'd8;
						end
						3'd3: if (val_q[63:60] == '0) begin
							val_q <= val_q << 4; e_q <= e_q - 6'd4;
						end
						3'd4: if (val_q[63:62] == '0) begin
							val_q <= val_q << 2; e_q <= e_q - 6'd2;
						end
						3'd5: if (!val_q[63]) begin
							val_q <= val_q << 1; e_q <= e_q - 6'd1;
						end
						default: begin
							m_q     <= val_q[63:33];
							frac_q  <= '0;
							it_q    <= '0;
							ph_q    <= 1'b0;
							state_q <= S_LOG;
						end
					endcase
				end
				S_LOG: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						if (sq[31]) begin
							m_q    <= sq[31:1];
							frac_q <= {frac_q[14:0], 1'b1};
						end else begin
							m_q    <= sq[30:0];
							frac_q <= {frac_q[14:0], 1'b0};
						end
						it_q <= it_q + 1'b1;
						if (it_q == 4'd15) begin
							state_q <= S_LNI;
						end
					end
				end
				S_LNI: begin
					state_q <= S_LNC;
				end
				S_LNC: begin
					if (!found_q || cost < best_cost_q) begin
						found_q     <= 1'b1;
						best_cost_q <= cost;
						best_slot_q <= j_q[LM_AW-1:0];
					end
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					j_q     <= j_q + 1'b1;
					state_q <= S_RD;
				end
				S_DONE: begin
					if (!m_valid_q || m_axis_tready) begin
						m_valid_q <= 1'b1;
						if (found_q) begin
							m_user_q <= ST_MATCHED;
							m_data_q <= OUT_DATA_W'(best_slot_q);
						end else begin
							m_user_q <= (obs_conf_q > conf_gate_q) ? ST_NEW : ST_NONE;
							m_data_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LM_CW'(MAX_LANDMARKS))
		else $error("landmark count beyond table size");

	a_append_inc: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("append did not advance the count");

	a_match_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && found_q && (!m_valid_q || m_axis_tready))
		|-> {1'b0, best_slot_q} < cnt_q)
		else $error("matched slot outside the filled table");

	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOG |-> val_q[63])
		else $error("determinant not normalised before the logarithm");

	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LOG |-> m_q[30])
		else $error("log mantissa left its range");

endmodule
